// ===== design/sfrt_pkg.sv =====
package sfrt_pkg;

	// Header layout
	localparam logic [3:0] HDR_LEN    = 4'd9;
	localparam logic [3:0] POS_ID_HI  = 4'd0;
	localparam logic [3:0] POS_ID_LO  = 4'd1;
	localparam logic [3:0] POS_FLAG   = 4'd2;
	localparam logic [3:0] POS_LEN_HI = 4'd7;
	localparam logic [3:0] POS_LEN_LO = 4'd8;

	// Header match values, the toggled bit and the target element identifier
	localparam logic [7:0] ID_HI     = 8'h09;
	localparam logic [7:0] ID_LO     = 8'h03;
	localparam logic [7:0] TOP_BIT   = 8'h80;
	localparam logic [7:0] TARGET_ID = 8'h54;

	// Information element layout
	localparam logic [16:0] ELEM_HDR   = 17'd4;
	localparam logic [16:0] OFF_ID     = 17'd0;
	localparam logic [16:0] OFF_LEN_HI = 17'd2;
	localparam logic [16:0] OFF_LEN_LO = 17'd3;
	localparam logic [16:0] OFF_TGT    = 17'd5;

	// Per-word control handed to the walker
	typedef struct packed {
		logic step;
		logic last;
	} sfrt_step_t;

endpackage

// ===== design/sfrt_walker.sv =====
module sfrt_walker import sfrt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  sfrt_step_t ctl,
	input  logic [7:0] data,
	output logic       flip
);

	logic [3:0]  hpos_q, hpos_n;
	logic        hmatch_q, hmatch_n;
	logic [16:0] body_q, body_n;
	logic [16:0] eoff_q, eoff_n;
	logic [15:0] elen_q, elen_n;
	logic        tgt_q, tgt_n;
	logic        done_q, done_n;
	logic [16:0] total;

	// Decode the current word against header position and element walk
	always_comb begin
		hpos_n   = hpos_q;
		hmatch_n = hmatch_q;
		body_n   = body_q;
		eoff_n   = eoff_q;
		elen_n   = elen_q;
		tgt_n    = tgt_q;
		done_n   = done_q;
		flip     = 1'b0;
		total    = {1'b0, elen_q} + ELEM_HDR;
		if (hpos_q < HDR_LEN) begin
			case (hpos_q)
				POS_ID_HI:  hmatch_n = (data == ID_HI);
				POS_ID_LO:  hmatch_n = hmatch_q && (data == ID_LO);
				POS_FLAG:   flip = hmatch_q;
				POS_LEN_HI: body_n = {1'b0, data, 8'h00};
				POS_LEN_LO: body_n = body_q | {9'b0, data};
				default: ;
			endcase
			hpos_n = hpos_q + 4'd1;
		end else if (hmatch_q && !done_q) begin
			if (eoff_q == OFF_ID) begin
				if (body_q == '0)
					done_n = 1'b1;
				else
					tgt_n = (data == TARGET_ID);
			end
			if (!done_n) begin
				if (tgt_n) begin
					if (eoff_q == OFF_TGT) begin
						flip   = 1'b1;
						done_n = 1'b1;
					end
					eoff_n = eoff_q + 17'd1;
				end else begin
					if (eoff_q == OFF_LEN_HI) begin
						elen_n = {8'h00, data};
					end else if (eoff_q == OFF_LEN_LO) begin
						elen_n = {elen_q[7:0], data};
						total  = {1'b0, elen_n} + ELEM_HDR;
						if (total >= body_q) begin
							body_n = '0;
							done_n = 1'b1;
						end else begin
							body_n = body_q - total;
						end
					end
					// Wrap to the next element after its last content byte
					if (eoff_q >= OFF_LEN_LO && eoff_q == {1'b0, elen_n} + OFF_LEN_LO)
						eoff_n = '0;
					else
						eoff_n = eoff_q + 17'd1;
				end
			end
		end
		// Drop all message state after the final word
		if (ctl.last) begin
			hpos_n   = '0;
			hmatch_n = 1'b0;
			body_n   = '0;
			eoff_n   = '0;
			elen_n   = '0;
			tgt_n    = 1'b0;
			done_n   = 1'b0;
		end
	end

	// Advance walk state once per processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpos_q   <= '0;
			hmatch_q <= 1'b0;
			body_q   <= '0;
			eoff_q   <= '0;
			elen_q   <= '0;
			tgt_q    <= 1'b0;
			done_q   <= 1'b0;
		end else if (ctl.step) begin
			hpos_q   <= hpos_n;
			hmatch_q <= hmatch_n;
			body_q   <= body_n;
			eoff_q   <= eoff_n;
			elen_q   <= elen_n;
			tgt_q    <= tgt_n;
			done_q   <= done_n;
		end
	end

endmodule

// ===== design/signalling_ref_flag_toggler.sv =====
// Datapath: an accepted input word passes through the input register, then the result register, to the output.
// Throughput: one word per cycle; s_tready stays high unless both registers are
// full and m_tready is low, in which case both stages hold.
// Reset: arst_n clears both stage valid flags and the walker state, so the next
// accepted word is taken as byte 0 of a new message.
module signalling_ref_flag_toggler import sfrt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // last_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // out_last
	output logic       m_tuser    // [0] flipped
);

	logic       valid_s1, last_s1;
	logic [7:0] data_s1;
	logic       valid_s2, last_s2, flip_s2;
	logic [7:0] data_s2;
	logic       adv;
	logic       flip;
	sfrt_step_t ctl;

	// Move words forward whenever the output register is free or draining
	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign ctl.step = valid_s1 && adv;
	assign ctl.last = last_s1;

	sfrt_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.data   (data_s1),
		.flip   (flip)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			data_s2 <= flip ? (data_s1 ^ TOP_BIT) : data_s1;
			last_s2 <= last_s1;
			flip_s2 <= flip;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tlast  = last_s2;
	assign m_tuser  = flip_s2;

endmodule

// ===== design/sfrt_checker.sv =====
module sfrt_checker import sfrt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	logic [3:0] pos_q;
	logic [1:0] flips_q;
	logic       out_acc;

	assign out_acc = m_tvalid && m_tready;

	// Track position and flip count of output words within a message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			flips_q <= '0;
		end else if (out_acc) begin
			if (m_tlast) begin
				pos_q   <= '0;
				flips_q <= '0;
			end else begin
				if (pos_q < HDR_LEN)
					pos_q <= pos_q + 4'd1;
				if (m_tuser && flips_q != 2'd3)
					flips_q <= flips_q + 2'd1;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	a_hdr_flip: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && m_tuser && pos_q < HDR_LEN |-> pos_q == POS_FLAG)
		else $error("header byte flipped outside the flag position");

	a_flip_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && m_tuser |-> flips_q < 2'd2)
		else $error("more than two flipped bytes in one message");

	a_no_out_without_in: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid, 2) && $past(s_tready, 2))
		else $error("output word without an accepted input word");

endmodule

bind signalling_ref_flag_toggler sfrt_checker u_sfrt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

// ===== tb/ref_flag_checker.sv =====
`timescale 1ns / 100ps

module ref_flag_checker import sfrt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // last_byte
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] out_byte
	input  logic       m_tlast,   // out_last
	input  logic       m_tuser,   // [0] flipped
	output int         errors,
	output int         pending
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       flip;
	} out_word_t;

	// Walker state, mirrors the block's message parser
	logic [3:0]  hdr_pos;
	logic        hdr_ok;
	logic [16:0] body_left;
	logic [16:0] elem_off;
	logic [15:0] elem_len;
	logic        elem_tgt;
	logic        walk_end;

	out_word_t expected_words[$];
	int        mismatch_count = 0;

	function automatic void clear_walk();
		hdr_pos   = '0;
		hdr_ok    = 1'b0;
		body_left = '0;
		elem_off  = '0;
		elem_len  = '0;
		elem_tgt  = 1'b0;
		walk_end  = 1'b0;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// Advance the walker by one byte and work out the word it should produce
	task automatic walk_byte(input logic [7:0] b, input logic l, output out_word_t w);
		logic        flip;
		logic [16:0] off;
		logic [16:0] elem_size;
		flip = 1'b0;
		if (hdr_pos < HDR_LEN) begin
			case (hdr_pos)
				POS_ID_HI:  hdr_ok = (b == ID_HI);
				POS_ID_LO:  hdr_ok = hdr_ok && (b == ID_LO);
				POS_FLAG:   flip = hdr_ok;
				POS_LEN_HI: body_left = {1'b0, b, 8'h00};
				POS_LEN_LO: body_left = body_left | {9'd0, b};
				default: ;
			endcase
			hdr_pos = hdr_pos + 4'd1;
		end else if (hdr_ok && !walk_end) begin
			off = elem_off;
			// a new element starts only while body bytes remain
			if (off == OFF_ID) begin
				if (body_left == '0)
					walk_end = 1'b1;
				else
					elem_tgt = (b == TARGET_ID);
			end
			if (!walk_end) begin
				if (elem_tgt) begin
					if (off == OFF_TGT) begin
						flip = 1'b1;
						walk_end = 1'b1;
					end
					elem_off = off + 17'd1;
				end else begin
					if (off == OFF_LEN_HI) begin
						elem_len = {8'h00, b};
					end else if (off == OFF_LEN_LO) begin
						elem_len = {elem_len[7:0], b};
						elem_size = {1'b0, elem_len} + ELEM_HDR;
						if (elem_size >= body_left) begin
							body_left = '0;
							walk_end = 1'b1;
						end else begin
							body_left = body_left - elem_size;
						end
					end
					// wrap to the next element after the last content byte
					if (off >= OFF_LEN_LO && off == {1'b0, elem_len} + OFF_LEN_LO)
						elem_off = '0;
					else
						elem_off = off + 17'd1;
				end
			end
		end
		w.data = flip ? (b ^ TOP_BIT) : b;
		w.last = l;
		w.flip = flip;
		if (l)
			clear_walk();
	endtask

	// Predict on accepted input words, compare on accepted output words
	always @(posedge clk or negedge arst_n) begin
		out_word_t w;
		if (!arst_n) begin
			clear_walk();
			expected_words.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				walk_byte(s_tdata, s_tlast, w);
				expected_words.push_back(w);
			end
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("output word %02h with nothing expected", m_tdata));
				end else begin
					w = expected_words.pop_front();
					if (m_tdata !== w.data)
						report_mismatch($sformatf("out_byte %02h, expected %02h", m_tdata, w.data));
					if (m_tlast !== w.last)
						report_mismatch($sformatf("out_last %b, expected %b", m_tlast, w.last));
					if (m_tuser !== w.flip)
						report_mismatch($sformatf("flipped %b, expected %b (byte %02h)",
							m_tuser, w.flip, w.data));
				end
			end
		end
		pending <= expected_words.size();
		errors  <= mismatch_count;
	end

endmodule

// ===== tb/signalling_ref_flag_toggler_tb.sv =====
`timescale 1ns / 100ps

module signalling_ref_flag_toggler_tb import sfrt_pkg::*;;

	localparam int IDLE_LIMIT  = 3000;
	localparam int TARGET_BYTES = 1600;

	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SLOW, RX_PERIODIC} rx_mode_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
	logic       s_tlast  = 1'b0;    // last_byte
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // [7:0] out_byte
	logic       m_tlast;            // out_last
	logic       m_tuser;            // [0] flipped

	int errors;
	int pending;

	int         burst_left = 0;
	int         sent_bytes = 0;
	int         idle_cycles = 0;
	rx_mode_t   rx_mode = RX_FREE;
	int         rx_left = 0;
	logic [7:0] msg_bytes[$];

	signalling_ref_flag_toggler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	ref_flag_checker ref_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stall the output side on a randomly chosen pattern, picked anew whenever its run ends
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(32, 256);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_FREE:     m_tready <= 1'b1;
			RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
			RX_SLOW:     m_tready <= ($urandom_range(0, 7) == 0);
			RX_PERIODIC: m_tready <= (rx_left[1:0] != 2'b00);
			default:     m_tready <= 1'b1;
		endcase
	end

	// End the run when no word moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Hand one word to the block, opening a new burst after a random gap
	task automatic send_word(input logic [7:0] b, input logic l);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(100, 300);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= l;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		sent_bytes++;
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_bytes.size(); i++)
			send_word(msg_bytes[i], i == msg_bytes.size() - 1);
	endtask

	task automatic push_element(input logic [7:0] id, input logic [15:0] len, input int n_body);
		msg_bytes.push_back(id);
		msg_bytes.push_back(8'($urandom_range(0, 255)));
		msg_bytes.push_back(len[15:8]);
		msg_bytes.push_back(len[7:0]);
		repeat (n_body) msg_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// Build a qualifying message: header, skipped elements, maybe a target element, maybe trailing bytes
	task automatic build_walk_message();
		int          n_elem;
		int          total;
		int          len;
		int          r;
		bit          stop;
		logic [7:0]  id;
		logic [15:0] body;
		msg_bytes = {};
		total = 0;
		stop = 1'b0;
		msg_bytes.push_back(ID_HI);
		msg_bytes.push_back(ID_LO);
		repeat (7) msg_bytes.push_back(8'($urandom_range(0, 255)));
		n_elem = $urandom_range(0, 4);
		for (int i = 0; i < n_elem && !stop; i++) begin
			id = 8'($urandom_range(0, 255));
			r = $urandom_range(0, 19);
			if (r < 14) begin
				len = $urandom_range(0, 5);
				push_element(id, 16'(len), len);
			end else if (r < 19) begin
				len = $urandom_range(6, 30);
				push_element(id, 16'(len), len);
			end else begin
				// random length field: at most six body bytes follow, so the message may run out inside the element
				len = $urandom_range(0, 65535);
				push_element(id, 16'(len), (len < 6) ? len : 6);
				stop = 1'b1;
			end
			total += len + 4;
		end
		if (!stop && $urandom_range(0, 9) < 7) begin
			len = $urandom_range(0, 6);
			push_element(TARGET_ID, 16'(len), $urandom_range(0, 1) ? len : $urandom_range(0, 4));
			total += len + 4;
		end
		repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom_range(0, 255)));
		case ($urandom_range(0, 6))
			0, 1: body = 16'(total);
			2:    body = 16'(total - $urandom_range(0, total));
			3:    body = 16'(total + $urandom_range(1, 20));
			4:    body = 16'h0000;
			5:    body = 16'($urandom_range(0, 65535));
			default: body = 16'hFFFF;
		endcase
		msg_bytes[POS_LEN_HI] = body[15:8];
		msg_bytes[POS_LEN_LO] = body[7:0];
		// cut some messages short at a random point
		if ($urandom_range(0, 9) == 0) begin
			len = $urandom_range(1, msg_bytes.size());
			while (msg_bytes.size() > len) void'(msg_bytes.pop_back());
		end
	endtask

	initial begin
		logic [7:0] late_target[15];
		int         kind;
		late_target = '{ID_HI, ID_LO, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h01,
			TARGET_ID, 8'h80, 8'h00, 8'h00, 8'h7F, 8'h00};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Message of one byte: ends before the header is matched
		send_word(ID_HI, 1'b1);
		// Header matched, ends right on the call reference flag
		send_word(ID_HI, 1'b0);
		send_word(ID_LO, 1'b0);
		send_word(8'hFF, 1'b1);
		// Second identifier byte wrong: nothing flips
		send_word(ID_HI, 1'b0);
		send_word(8'h04, 1'b0);
		send_word(8'h80, 1'b1);
		// Target element past a one-byte body with a zero length field
		for (int i = 0; i < 15; i++)
			send_word(late_target[i], i == 14);

		// Mostly well-formed messages, some with a broken header, some noise
		while (sent_bytes < TARGET_BYTES) begin
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				build_walk_message();
			end else if (kind < 17) begin
				build_walk_message();
				msg_bytes[$urandom_range(0, 1)] = 8'($urandom_range(0, 255));
			end else begin
				msg_bytes = {};
				repeat ($urandom_range(1, 20)) msg_bytes.push_back(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1))
					msg_bytes[0] = ID_HI;
			end
			send_message();
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		// Drain, then allow the pipeline to settle
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
